@@ src/rat_pkg.sv @@
// ============================================================================
// rat_pkg
// Shared widths, codes and state encoding for the region address translator.
// ============================================================================
package rat_pkg;

    // Field widths.
    localparam int ADDR_W   = 64;
    localparam int OFF_W    = 40;
    localparam int LEN_W    = 32;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = ADDR_W + OFF_W;

    // Configuration register indexes.
    localparam logic CFG_FILE_SIZE    = 1'b0;
    localparam logic CFG_REGION_COUNT = 1'b1;

    // Command codes.
    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BELOW   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_CROSSES = 2'd2;
    localparam logic [STATUS_W-1:0] STS_WRITTEN = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_CALC  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_REPLY = 5'b10000
    } state_t;

endpackage

@@ src/region_address_translator.sv @@
// ============================================================================
// region_address_translator
// Region table lookup that turns an address and length into a file offset.
// ============================================================================
// A write item goes straight to the reply state. A translate item scans the
// table RAM downward from the top live entry, one entry read per cycle, until
// an entry matches, then passes through the calc and check states; one that
// matches nothing, or finds no live region, goes to the reply state. One item
// is in work at a time; a finished result waits in the output register while
// the next item is accepted. Reset clears the control state and both
// configuration registers; the table RAM holds no reset value.
module region_address_translator #(
    parameter int REGION_ENTRIES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [rat_pkg::OFF_W-1:0]      cfg_data,

    // Request channel.
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           cmd,
    input  logic [rat_pkg::SLOT_W-1:0]     entry_index,
    input  logic [rat_pkg::ADDR_W-1:0]     entry_base,
    input  logic [rat_pkg::OFF_W-1:0]      region_file_offset,
    input  logic [rat_pkg::ADDR_W-1:0]     address,
    input  logic [rat_pkg::LEN_W-1:0]      length,

    // Response channel.
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [rat_pkg::STATUS_W-1:0]   status,
    output logic [rat_pkg::OFF_W-1:0]      file_offset
);

    import rat_pkg::*;

    localparam int IDX_W = $clog2(REGION_ENTRIES);
    localparam int CNT_W = $clog2(REGION_ENTRIES + 1);

    // Configuration registers.
    logic [OFF_W-1:0]   file_size_reg;
    logic [COUNT_W-1:0] region_count_reg;

    // Control state.
    state_t             state_reg, state_next;
    logic               issue_ok_reg, issue_ok_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Working payload.
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]    cur_idx_reg, cur_idx_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [OFF_W-1:0]    prev_off_reg, prev_off_next;
    logic [OFF_W-1:0]    own_reg, own_next;
    logic [OFF_W-1:0]    nxt_reg, nxt_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [OFF_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]   delta_reg, delta_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [OFF_W-1:0]    rsp_off_reg, rsp_off_next;

    // Table RAM interface.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ADDR_W-1:0]  ram_base;
    logic [OFF_W-1:0]   ram_off;

    // Helper signals.
    logic               req_accept;
    logic               rsp_free;
    logic               count_over;
    logic [CNT_W-1:0]   n_eff;
    logic               slot_ok;
    logic               hit;
    logic               over_end;
    logic [OFF_W-1:0]   room;
    logic               too_long;
    logic [STATUS_W-1:0] chk_status;
    logic [OFF_W-1:0]   chk_off;

    // Handshakes.
    assign cfg_ready  = 1'b1;
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign file_offset = rsp_off_reg;

    // Effective region count, limited to the table depth.
    assign count_over = (32'(region_count_reg) > 32'(REGION_ENTRIES));
    assign n_eff      = count_over ? CNT_W'(REGION_ENTRIES) : CNT_W'(region_count_reg);
    assign slot_ok    = (32'(entry_index) < 32'(REGION_ENTRIES));

    // Table RAM holds base and offset side by side.
    assign ram_we    = req_accept && (cmd == CMD_WRITE) && slot_ok;
    assign ram_waddr = IDX_W'(entry_index);
    assign ram_wdata = {entry_base, region_file_offset};
    assign ram_re    = (state_reg == ST_SCAN) && issue_ok_reg;
    assign ram_base  = ram_rdata[ENTRY_W-1:OFF_W];
    assign ram_off   = ram_rdata[OFF_W-1:0];

    rat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (REGION_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    // Entry returned from the RAM matches when its base is not above the address.
    assign hit = rd_pend_reg && (ram_base <= addr_reg);

    // Bound check on the chosen region.
    assign over_end   = (delta_reg > ADDR_W'(size_reg));
    assign room       = size_reg - delta_reg[OFF_W-1:0];
    assign too_long   = (OFF_W'(len_reg) > room);
    assign chk_status = (over_end || too_long) ? STS_CROSSES : STS_OK;
    assign chk_off    = (over_end || too_long) ? '0 : own_reg + delta_reg[OFF_W-1:0];

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        issue_ok_next   = issue_ok_reg;
        rd_pend_next    = rd_pend_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        n_next          = n_reg;
        issue_idx_next  = issue_idx_reg;
        cur_idx_next    = cur_idx_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        prev_off_next   = prev_off_reg;
        own_next        = own_reg;
        nxt_next        = nxt_reg;
        base_next       = base_reg;
        size_next       = size_reg;
        delta_next      = delta_reg;
        res_status_next = res_status_reg;
        rsp_status_next = rsp_status_reg;
        rsp_off_next    = rsp_off_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        res_status_next = STS_WRITTEN;
                        state_next      = ST_REPLY;
                    end
                    else
                    begin
                        n_next        = n_eff;
                        addr_next     = address;
                        len_next      = length;
                        // The last region is bounded by the file size.
                        prev_off_next = file_size_reg;
                        rd_pend_next  = 1'b0;
                        if (n_eff == '0)
                        begin
                            res_status_next = STS_BELOW;
                            state_next      = ST_REPLY;
                        end
                        else
                        begin
                            issue_idx_next = IDX_W'(n_eff - 1'b1);
                            issue_ok_next  = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle, walking down from the top entry.
                rd_pend_next = issue_ok_reg;
                cur_idx_next = issue_idx_reg;
                if (issue_ok_reg)
                begin
                    issue_idx_next = issue_idx_reg - 1'b1;
                    issue_ok_next  = (issue_idx_reg != '0);
                end
                if (rd_pend_reg)
                begin
                    if (hit)
                    begin
                        base_next     = ram_base;
                        own_next      = ram_off;
                        nxt_next      = prev_off_reg;
                        issue_ok_next = 1'b0;
                        state_next    = ST_CALC;
                    end
                    else
                    begin
                        // This missed entry's offset bounds the next lower region.
                        prev_off_next = ram_off;
                        if (cur_idx_reg == '0)
                        begin
                            res_status_next = STS_BELOW;
                            state_next      = ST_REPLY;
                        end
                    end
                end
            end

            ST_CALC:
            begin
                // Region size clamps at zero; position inside the region.
                size_next  = (nxt_reg >= own_reg) ? nxt_reg - own_reg : '0;
                delta_next = addr_reg - base_reg;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = chk_status;
                    rsp_off_next    = chk_off;
                    state_next      = ST_IDLE;
                end
            end

            ST_REPLY:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_off_next    = '0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_ok_reg     <= 1'b0;
            rd_pend_reg      <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            file_size_reg    <= '0;
            region_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_ok_reg  <= issue_ok_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FILE_SIZE:    file_size_reg    <= cfg_data;
                    CFG_REGION_COUNT: region_count_reg <= cfg_data[COUNT_W-1:0];
                    default:          file_size_reg    <= file_size_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        issue_idx_reg  <= issue_idx_next;
        cur_idx_reg    <= cur_idx_next;
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        prev_off_reg   <= prev_off_next;
        own_reg        <= own_next;
        nxt_reg        <= nxt_next;
        base_reg       <= base_next;
        size_reg       <= size_next;
        delta_reg      <= delta_next;
        res_status_reg <= res_status_next;
        rsp_status_reg <= rsp_status_next;
        rsp_off_reg    <= rsp_off_next;
    end

    // A new result only comes out of one of the two result states.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_CHECK || state_reg == ST_REPLY))
        else $error("response raised outside a result state");

    // A rejected or write result never carries a file offset.
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STS_OK) |-> (file_offset == '0))
        else $error("nonzero offset on a non-translated result");

    // Data that comes back during the scan belongs to a valid entry.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && rd_pend_reg |-> (CNT_W'(cur_idx_reg) < n_reg))
        else $error("scan read beyond the region count");

endmodule

@@ src/rat_ram.sv @@
// ============================================================================
// rat_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module rat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data is registered when re is high and appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
